[rtl/hfv_pkg.sv]
// Package for the header field validator: item struct, status codes,
// the key character bitmap and the slice length limits.
// Depends on nothing.
`timescale 1ns / 1ps

package hfv_pkg;

	localparam int MAX_LEN = 4096;
	localparam int POS_W   = 12;
	localparam int POS_CAP = ((MAX_LEN - 1) < 4095) ? (MAX_LEN - 1) : 4095;

	localparam logic [7:0]  COLON_CHAR = 8'h3a;
	localparam logic [31:0] BIN_SUFFIX = 32'h2d62696e;

	// one bit per byte value, set where the byte may appear in a key
	localparam logic [255:0] KEY_MAP = {128'h0, 128'h07ff_fffe_8000_0000_03ff_6000_0000_0000};

	typedef enum logic [1:0] {
		ST_LEGAL     = 2'd0,
		ST_EMPTY_KEY = 2'd1,
		ST_COLON     = 2'd2,
		ST_ILLEGAL   = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_key;
		logic       first_byte;
		logic       last_byte;
		logic       empty_slice;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} stage_t;

	function automatic logic byte_legal(input logic [7:0] b, input logic key);
		logic ok;
		if (key) begin
			ok = KEY_MAP[b];
		end else begin
			ok = (b >= 8'd32) && (b <= 8'd126);
		end
		return ok;
	endfunction

endpackage

[rtl/hfv_in_reg.sv]
// Input register of the header field validator.
// Holds one transfer and releases it when the slice stage takes it.
// Depends on hfv_pkg.
`timescale 1ns / 1ps

module hfv_in_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  hfv_pkg::item_t in_item,
	input  logic           take,
	output hfv_pkg::stage_t stage_s1
);
	import hfv_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	logic  accept;

	assign in_stall = valid_s1 && !take;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
		end
	end

	assign stage_s1.valid = valid_s1;
	assign stage_s1.item  = item_s1;

endmodule

[rtl/hfv_core.sv]
// Slice state and result register of the header field validator.
// Checks one byte per cycle while no stalled result blocks it, and records the first error of the slice.
// Depends on hfv_pkg.
`timescale 1ns / 1ps

module hfv_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  hfv_pkg::stage_t           stage_s1,
	output logic                      take,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [1:0]                status,
	output logic [hfv_pkg::POS_W-1:0] error_offset,
	output logic                      is_binary
);
	import hfv_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic             key_q;
	logic             err_q;
	status_t          kind_q;
	logic [POS_W-1:0] eoff_q;
	logic [31:0]      tail_q;

	logic             out_valid_q;
	status_t          status_q;
	logic [POS_W-1:0] error_offset_q;
	logic             is_binary_q;

	item_t            it;
	logic             has_result;
	logic             out_free;
	logic [POS_W-1:0] cur_pos;
	logic             cur_key;
	logic             cur_err;
	status_t          cur_kind;
	logic [POS_W-1:0] cur_eoff;
	logic [31:0]      cur_tail;
	logic [POS_W:0]   pos_inc;
	logic [POS_W-1:0] pos_next;
	logic             new_err;
	status_t          new_kind;
	logic [POS_W-1:0] new_eoff;
	status_t          res_status;
	logic [POS_W-1:0] res_offset;
	logic             res_binary;

	assign it         = stage_s1.item;
	assign has_result = it.empty_slice || it.last_byte;
	assign out_free   = !out_valid_q || !out_stall;
	assign take       = stage_s1.valid && (!has_result || out_free);

	always_comb begin
		cur_pos  = it.first_byte ? '0 : pos_q;
		cur_key  = it.first_byte ? it.is_key : key_q;
		cur_err  = it.first_byte ? 1'b0 : err_q;
		cur_kind = it.first_byte ? ST_LEGAL : kind_q;
		cur_eoff = it.first_byte ? '0 : eoff_q;
		cur_tail = {(it.first_byte ? 24'h0 : tail_q[23:0]), it.data_byte};

		new_err  = cur_err;
		new_kind = cur_kind;
		new_eoff = cur_eoff;
		if (!cur_err) begin
			if (cur_key && (cur_pos == '0) && (it.data_byte == COLON_CHAR)) begin
				new_err  = 1'b1;
				new_kind = ST_COLON;
				new_eoff = '0;
			end else if (!byte_legal(it.data_byte, cur_key)) begin
				new_err  = 1'b1;
				new_kind = ST_ILLEGAL;
				new_eoff = cur_pos;
			end
		end

		pos_inc  = {1'b0, cur_pos} + (POS_W + 1)'(1);
		pos_next = (pos_inc > (POS_W + 1)'(POS_CAP)) ? POS_W'(POS_CAP) : pos_inc[POS_W-1:0];

		if (it.empty_slice) begin
			res_status = it.is_key ? ST_EMPTY_KEY : ST_LEGAL;
			res_offset = '0;
			res_binary = 1'b0;
		end else begin
			res_status = new_err ? new_kind : ST_LEGAL;
			res_offset = new_err ? new_eoff : '0;
			res_binary = (cur_pos >= POS_W'(4)) && (cur_tail == BIN_SUFFIX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			key_q  <= 1'b0;
			err_q  <= 1'b0;
			kind_q <= ST_LEGAL;
			eoff_q <= '0;
			tail_q <= '0;
		end else if (take) begin
			if (it.empty_slice) begin
				pos_q  <= '0;
				key_q  <= it.is_key;
				err_q  <= 1'b0;
				kind_q <= ST_LEGAL;
				eoff_q <= '0;
				tail_q <= '0;
			end else begin
				pos_q  <= pos_next;
				key_q  <= cur_key;
				err_q  <= new_err;
				kind_q <= new_kind;
				eoff_q <= new_eoff;
				tail_q <= cur_tail;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && has_result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && has_result) begin
			status_q       <= res_status;
			error_offset_q <= res_offset;
			is_binary_q    <= res_binary;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign error_offset = error_offset_q;
	assign is_binary    = is_binary_q;

endmodule

[rtl/header_field_validator.sv]
// Header field validator: checks HTTP/2 header names and values one byte per
// transfer and returns one result per slice, on its last byte or on an empty-
// slice transfer. One byte is taken in every cycle unless the input side
// stalls; a byte passes through an input register and a result register,
// with the slice checks between them. The input side stalls only while a
// stalled result waits in the result register and the byte held in the
// input register would produce another. Depends on hfv_pkg, hfv_in_reg and
// hfv_core.
`timescale 1ns / 1ps

module header_field_validator (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                data_byte,
	input  logic                      is_key,
	input  logic                      first_byte,
	input  logic                      last_byte,
	input  logic                      empty_slice,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [1:0]                status,
	output logic [hfv_pkg::POS_W-1:0] error_offset,
	output logic                      is_binary
);
	import hfv_pkg::*;

	item_t  in_item;
	stage_t stage_s1;
	logic   take;

	assign in_item.data_byte   = data_byte;
	assign in_item.is_key      = is_key;
	assign in_item.first_byte  = first_byte;
	assign in_item.last_byte   = last_byte;
	assign in_item.empty_slice = empty_slice;

	hfv_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.take     (take),
		.stage_s1 (stage_s1)
	);

	hfv_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.stage_s1     (stage_s1),
		.take         (take),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.error_offset (error_offset),
		.is_binary    (is_binary)
	);

endmodule

[rtl/hfv_checker.sv]
// Port-level checks for the header field validator, bound to its top level.
// Depends on hfv_pkg and header_field_validator.
`timescale 1ns / 1ps

module hfv_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [1:0]                status,
	input logic [hfv_pkg::POS_W-1:0] error_offset,
	input logic                      is_binary
);
	import hfv_pkg::*;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(status) && $stable(error_offset))
		else $error("stalled result changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_ILLEGAL) |-> error_offset == '0)
		else $error("offset set without an illegal byte");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_EMPTY_KEY) |-> !is_binary)
		else $error("empty key flagged as binary");

endmodule

bind header_field_validator hfv_checker u_hfv_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.status       (status),
	.error_offset (error_offset),
	.is_binary    (is_binary)
);

[tb/tb_header_field_validator.sv]
// Self-checking testbench for header_field_validator: directed and random header
// slices, randomised input idling and output stall, results scoreboarded in order.
// Depends on hfv_pkg and the header_field_validator RTL.
`timescale 1ns / 1ps

module tb_header_field_validator;
	import hfv_pkg::*;

	localparam logic [7:0]  COLON    = 8'h3a;
	localparam logic [31:0] BIN_TAIL = "-bin";
	localparam int          OFF_CAP  = ((MAX_LEN - 1) < 4095) ? (MAX_LEN - 1) : 4095;
	localparam int          RANDOM_ITEMS = 1850;

	typedef struct packed {
		status_t     status;
		logic [11:0] offset;
		logic        bin_tail;
	} slice_verdict_t;

	class slice_scoreboard;
		logic [11:0]    pos;
		logic           key_mode;
		logic           err_seen;
		status_t        err_kind;
		logic [11:0]    err_off;
		logic [31:0]    tail;
		slice_verdict_t verdict_q[$];
		int             mismatches;

		function new();
			clear_slice();
			key_mode   = 1'b0;
			mismatches = 0;
		endfunction

		function void clear_slice();
			pos      = '0;
			err_seen = 1'b0;
			err_kind = ST_LEGAL;
			err_off  = '0;
			tail     = '0;
		endfunction

		function bit key_char_ok(logic [7:0] b);
			return b == "-" || b == "." || b == "_" || (b >= "0" && b <= "9") ||
				(b >= "a" && b <= "z");
		endfunction

		function void note_transfer(logic [7:0] b, logic key, logic first, logic last,
				logic empty);
			slice_verdict_t v;
			logic [11:0]    off;
			bit             ok;
			if (empty) begin
				clear_slice();
				key_mode   = key;
				v.status   = key ? ST_EMPTY_KEY : ST_LEGAL;
				v.offset   = '0;
				v.bin_tail = 1'b0;
				verdict_q.push_back(v);
				return;
			end
			if (first) begin
				clear_slice();
				key_mode = key;
			end
			off  = pos;
			tail = {tail[23:0], b};
			ok   = key_mode ? key_char_ok(b) : (b >= 8'd32 && b <= 8'd126);
			if (!err_seen) begin
				if (key_mode && off == 0 && b == COLON) begin
					err_seen = 1'b1;
					err_kind = ST_COLON;
					err_off  = '0;
				end else if (!ok) begin
					err_seen = 1'b1;
					err_kind = ST_ILLEGAL;
					err_off  = off;
				end
			end
			pos = (int'(off) + 1 > OFF_CAP) ? 12'(OFF_CAP) : off + 12'd1;
			if (!last)
				return;
			v.status   = err_seen ? err_kind : ST_LEGAL;
			v.offset   = err_seen ? err_off : 12'd0;
			v.bin_tail = (off >= 12'd4) && (tail == BIN_TAIL);
			verdict_q.push_back(v);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_result(logic [1:0] st, logic [11:0] off, logic bin);
			slice_verdict_t v;
			if (verdict_q.size() == 0) begin
				report($sformatf("unexpected result status=%0d offset=%0d bin=%0d",
					st, off, bin));
				return;
			end
			v = verdict_q.pop_front();
			if (st !== v.status)
				report($sformatf("status %0d, want %0d", st, v.status));
			if (off !== v.offset)
				report($sformatf("error_offset %0d, want %0d", off, v.offset));
			if (bin !== v.bin_tail)
				report($sformatf("is_binary %0d, want %0d", bin, v.bin_tail));
		endtask

		task flush_leftovers();
			while (verdict_q.size() != 0) begin
				void'(verdict_q.pop_front());
				report("result never arrived");
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte   = '0;
	logic        is_key      = 1'b0;
	logic        first_byte  = 1'b0;
	logic        last_byte   = 1'b0;
	logic        empty_slice = 1'b0;
	logic        out_valid;
	logic        out_stall   = 1'b0;
	logic [1:0]  status;
	logic [11:0] error_offset;
	logic        is_binary;

	slice_scoreboard sb = new();
	int sent_items;
	bit quiet;
	bit hold_req;

	header_field_validator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.is_key       (is_key),
		.first_byte   (first_byte),
		.last_byte    (last_byte),
		.empty_slice  (empty_slice),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.error_offset (error_offset),
		.is_binary    (is_binary)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.note_transfer(data_byte, is_key, first_byte, last_byte, empty_slice);
		if (arst_n && out_valid && !out_stall)
			sb.check_result(status, error_offset, is_binary);
	end

	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = 400;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else
				out_stall <= !quiet && ($urandom_range(99) < 8);
		end
	end

	task automatic send_item(input logic [7:0] b, input logic key, input logic first,
			input logic last, input logic empty);
		int gap;
		if (!quiet && $urandom_range(99) < 6) begin
			gap = $urandom_range(1, 2);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		data_byte   <= b;
		is_key      <= key;
		first_byte  <= first;
		last_byte   <= last;
		empty_slice <= empty;
		do @(posedge clk); while (in_stall);
		sent_items++;
	endtask

	task automatic send_bytes(input logic key, input logic [7:0] q[$], input bit mark_first,
			input bit mark_last);
		for (int i = 0; i < q.size(); i++)
			send_item(q[i], (i == 0) ? key : 1'($urandom_range(1)), mark_first && i == 0,
				mark_last && i == q.size() - 1, 1'b0);
	endtask

	task automatic send_text(input logic key, input string s);
		logic [7:0] q[$];
		if (s.len() == 0) begin
			send_item(8'($urandom_range(255)), key, 1'($urandom_range(1)),
				1'($urandom_range(1)), 1'b1);
			return;
		end
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i]);
		send_bytes(key, q, 1'b1, 1'b1);
	endtask

	function automatic logic [7:0] key_char();
		int r;
		r = $urandom_range(38);
		if (r == 0)
			return "-";
		if (r == 1)
			return ".";
		if (r == 12)
			return "_";
		if (r < 12)
			return 8'("0" + r - 2);
		return 8'("a" + r - 13);
	endfunction

	task automatic random_slice();
		logic [7:0] q[$];
		logic       key;
		int         len;
		key = 1'($urandom_range(1));
		len = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
		if (len == 0) begin
			send_text(key, "");
			return;
		end
		for (int i = 0; i < len; i++)
			q.push_back(key ? key_char() : 8'($urandom_range(32, 126)));
		if (len >= 4 && $urandom_range(3) == 0) begin
			q[len-4] = "-";
			q[len-3] = "b";
			q[len-2] = "i";
			q[len-1] = "n";
		end
		if ($urandom_range(5) == 0)
			q[$urandom_range(len - 1)] = 8'($urandom_range(255));
		if (key && $urandom_range(7) == 0)
			q[0] = COLON;
		send_bytes(key, q, $urandom_range(19) != 0, $urandom_range(19) != 0);
	endtask

	initial begin
		int rand_start;
		bit held;
		bit drained;
		held    = 1'b0;
		drained = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: continuation after reset, suffixes, colon, empties, byte extremes
		send_item("a", 1'b1, 1'b0, 1'b1, 1'b0);
		send_text(1'b1, "x-bin");
		send_text(1'b1, "-bin");
		send_text(1'b1, ":ab");
		send_text(1'b1, "aB");
		send_text(1'b1, "a:");
		send_text(1'b1, "az09-._");
		send_text(1'b1, "");
		send_text(1'b0, "");
		send_item(8'hff, 1'b1, 1'b1, 1'b1, 1'b1);
		send_item(8'h20, 1'b0, 1'b1, 1'b0, 1'b0);
		send_item(8'h7e, 1'b0, 1'b0, 1'b1, 1'b0);
		send_item(8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
		send_item(8'hff, 1'b0, 1'b1, 1'b1, 1'b0);
		send_item(8'h7f, 1'b0, 1'b1, 1'b1, 1'b0);
		send_item(8'h1f, 1'b0, 1'b1, 1'b1, 1'b0);
		send_text(1'b0, "x-bin");

		rand_start = sent_items;
		while (sent_items < rand_start + RANDOM_ITEMS) begin
			quiet = (sent_items - rand_start) inside {[700:1000]};
			if (!held && (sent_items - rand_start) >= 300) begin
				held     = 1'b1;
				hold_req = 1'b1;
			end
			if (!drained && (sent_items - rand_start) >= 1200) begin
				drained = 1'b1;
				in_valid <= 1'b0;
				do @(posedge clk); while (sb.verdict_q.size() != 0);
			end
			if ($urandom_range(9) == 0)
				send_item(8'($urandom_range(255)), 1'($urandom_range(1)),
					1'($urandom_range(1)), 1'($urandom_range(1)),
					1'($urandom_range(7) == 0));
			else
				random_slice();
		end
		in_valid <= 1'b0;

		while (sb.verdict_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		sb.flush_leftovers();
		if (sb.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
